FILE: rtl/core/positional_array_list_engine_assert.svh
// ----------------------------------------------------------------------------
// positional array list engine assertion macros
// short forms for clocked, reset-gated concurrent checks
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define PALE_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pale check failed");

// next-cycle implication
`define PALE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pale check failed");

`endif

FILE: rtl/core/pale_pkg.sv
// ----------------------------------------------------------------------------
// pale_pkg
// shared types and constants of the positional array list engine
// ----------------------------------------------------------------------------
package pale_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int POS_W        = 8;
   localparam int FUNC_W       = 4;
   localparam int STATUS_W     = 3;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 48;

   // command codes
   typedef enum logic [FUNC_W-1:0] {
      FN_INS_END   = 4'd0,
      FN_INS_FRONT = 4'd1,
      FN_INS_AT    = 4'd2,
      FN_MOD_END   = 4'd3,
      FN_MOD_FRONT = 4'd4,
      FN_MOD_AT    = 4'd5,
      FN_DEL_END   = 4'd6,
      FN_DEL_FRONT = 4'd7,
      FN_DEL_AT    = 4'd8,
      FN_REVERSE   = 4'd9,
      FN_SUM       = 4'd10,
      FN_SEARCH    = 4'd11,
      FN_READ      = 4'd12
   } pale_func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } pale_status_type;

   // sequencer states
   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_WALK,
      SQ_REV_RLO,
      SQ_REV_RHI,
      SQ_REV_WLO,
      SQ_REV_WHI,
      SQ_FINISH
   } pale_state_type;

   // entry memory port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } pale_mem_ctl_type;

endpackage

FILE: rtl/core/pale_ram.sv
// ----------------------------------------------------------------------------
// pale_ram
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pale_ram #(
   parameter int DEPTH = pale_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                             clock,
   input  pale_pkg::pale_mem_ctl_type       ctl,
   input  logic [AW-1:0]                    wr_addr,
   input  logic signed [pale_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]                    rd_addr,
   output logic signed [pale_pkg::DATA_W-1:0] rd_data
);
   import pale_pkg::*;

   logic signed [DATA_W-1:0] mem_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/positional_array_list_engine.sv
// ----------------------------------------------------------------------------
// positional_array_list_engine
// packed list of signed 32-bit entries with insert, modify, delete, reverse,
// sum, search and read commands
// ----------------------------------------------------------------------------
// Each command item yields exactly one result item. The entries live in a
// single-port-read, single-port-write memory, and a small sequencer walks it
// one entry per cycle: shifts for inserts and deletes, the running sum, the
// search compare and a single read all stream through that one read port.
// Reverse swaps one pair at a time: read low, read high, write low, write high.
// Modify, delete at the end, errors and unused codes need no walk. The
// block accepts one item at a time; a finished result sits in an output
// register so the next item is taken while it waits. No clearing pass is
// needed after reset: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module positional_array_list_engine #(
   parameter int CAPACITY = pale_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // command items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pale_pkg::REQ_DATA_W-1:0]    req_tdata,  // value[31:0], position[39:32]
   input  logic [pale_pkg::FUNC_W-1:0]        req_tuser,  // func[3:0]
   // result items
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pale_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // data[31:0], found_index[39:32],
                                                          // fill_count[47:40]
   output logic [pale_pkg::STATUS_W-1:0]      rsp_tuser   // status[2:0]
);
   import pale_pkg::*;

   localparam int IW = $clog2(CAPACITY);      // entry index width
   localparam int CW = $clog2(CAPACITY + 1);  // fill count width

   // sequencer and walk control
   pale_state_type            state_ff, state_in;
   pale_func_type             func_ff, func_in;
   logic signed [DATA_W-1:0]  value_ff, value_in;
   logic [IW-1:0]             ptr_ff, ptr_in;     // next read address / low swap index
   logic [IW-1:0]             end_ff, end_in;     // last read address / high swap index
   logic                      up_ff, up_in;       // walk direction
   logic                      more_ff, more_in;   // reads still to issue
   logic                      rd_vld_ff, rd_vld_in;
   logic [IW-1:0]             addr_q_ff, addr_q_in;
   logic signed [DATA_W-1:0]  tmp_ff, tmp_in;     // low entry held during a swap
   logic signed [DATA_W-1:0]  acc_ff, acc_in;     // sum or read data
   logic [CW-1:0]             count_ff, count_in;

   // result waiting for the output register
   pale_status_type           res_status_ff, res_status_in;
   logic [IW-1:0]             res_found_ff, res_found_in;

   // output register
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]          rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]          rsp_fill_ff, rsp_fill_in;

   // memory port
   pale_mem_ctl_type          mem_ctl;
   logic [IW-1:0]             wr_addr;
   logic signed [DATA_W-1:0]  wr_data;
   logic [IW-1:0]             rd_addr;
   logic signed [DATA_W-1:0]  rd_data;

   // request fields
   logic signed [DATA_W-1:0]  req_value;
   logic [POS_W-1:0]          req_pos;
   logic [POS_W:0]            pos_x;
   logic [POS_W:0]            cnt_x;
   logic [IW-1:0]             cnt_idx;
   logic [IW-1:0]             last_idx;
   logic [IW-1:0]             tgt_idx;
   logic                      list_empty;
   logic                      list_full;
   logic                      accept;
   logic                      out_free;

   assign req_value  = req_tdata[DATA_W-1:0];
   assign req_pos    = req_tdata[DATA_W+POS_W-1:DATA_W];
   assign pos_x      = {1'b0, req_pos};
   assign cnt_x      = (POS_W+1)'(count_ff);
   assign cnt_idx    = IW'(count_ff);
   assign last_idx   = IW'(count_ff - CW'(1));
   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == CW'(CAPACITY));
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign req_tready = (state_ff == SQ_IDLE);

   pale_ram #(
      .DEPTH (CAPACITY),
      .AW    (IW)
   ) u_pale_ram (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer: decode on accept, walk the memory, then hand off the result
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      value_in      = value_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      up_in         = up_ff;
      more_in       = more_ff;
      rd_vld_in     = (state_ff == SQ_WALK) && more_ff;
      addr_q_in     = ptr_ff;
      tmp_in        = tmp_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fill_in   = rsp_fill_ff;
      mem_ctl       = '0;
      wr_addr       = '0;
      wr_data       = value_ff;
      rd_addr       = ptr_ff;
      tgt_idx       = '0;

      unique case (state_ff)
         SQ_IDLE: begin
            if (accept) begin
               func_in       = pale_func_type'(req_tuser);
               value_in      = req_value;
               acc_in        = '0;
               res_status_in = ST_OK;
               res_found_in  = '0;
               more_in       = 1'b0;
               state_in      = SQ_FINISH;
               unique case (pale_func_type'(req_tuser)) inside
                  FN_INS_END, FN_INS_FRONT, FN_INS_AT: begin
                     if (list_full) begin
                        res_status_in = ST_FULL;
                     end else if (req_tuser == FN_INS_AT && pos_x > cnt_x) begin
                        res_status_in = ST_BADPOS;
                     end else begin
                        // shift entries from the top down to the slot
                        if (req_tuser == FN_INS_END) begin
                           tgt_idx = cnt_idx;
                        end else if (req_tuser == FN_INS_FRONT) begin
                           tgt_idx = '0;
                        end else begin
                           tgt_idx = IW'(req_pos);
                        end
                        ptr_in   = last_idx;
                        end_in   = tgt_idx;
                        up_in    = 1'b0;
                        more_in  = (tgt_idx != cnt_idx);
                        state_in = SQ_WALK;
                     end
                  end
                  FN_MOD_END: begin
                     if (list_empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = last_idx;
                        wr_data       = req_value;
                     end
                  end
                  FN_MOD_FRONT: begin
                     if (list_empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = '0;
                        wr_data       = req_value;
                     end
                  end
                  FN_MOD_AT: begin
                     if (pos_x >= cnt_x) begin
                        res_status_in = ST_BADPOS;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = IW'(req_pos);
                        wr_data       = req_value;
                     end
                  end
                  FN_DEL_END: begin
                     if (list_empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  FN_DEL_FRONT, FN_DEL_AT: begin
                     if (list_empty) begin
                        res_status_in = ST_EMPTY;
                     end else if (req_tuser == FN_DEL_AT && pos_x >= cnt_x) begin
                        res_status_in = ST_BADPOS;
                     end else begin
                        // pull later entries down over the removed slot
                        tgt_idx  = (req_tuser == FN_DEL_FRONT) ? '0 : IW'(req_pos);
                        ptr_in   = tgt_idx + IW'(1);
                        end_in   = last_idx;
                        up_in    = 1'b1;
                        more_in  = (tgt_idx != last_idx);
                        state_in = SQ_WALK;
                     end
                  end
                  FN_REVERSE: begin
                     ptr_in = '0;
                     end_in = last_idx;
                     if (count_ff >= CW'(2)) begin
                        state_in = SQ_REV_RLO;
                     end
                  end
                  FN_SUM, FN_SEARCH: begin
                     ptr_in   = '0;
                     end_in   = last_idx;
                     up_in    = 1'b1;
                     more_in  = !list_empty;
                     state_in = SQ_WALK;
                  end
                  FN_READ: begin
                     if (pos_x >= cnt_x) begin
                        res_status_in = ST_BADPOS;
                     end else begin
                        ptr_in   = IW'(req_pos);
                        end_in   = IW'(req_pos);
                        up_in    = 1'b1;
                        more_in  = 1'b1;
                        state_in = SQ_WALK;
                     end
                  end
                  default: begin
                     // unused codes leave the list alone
                  end
               endcase
            end
         end

         SQ_WALK: begin
            // issue one read per cycle until the end address
            if (more_ff) begin
               mem_ctl.rd_en = 1'b1;
               ptr_in        = up_ff ? ptr_ff + IW'(1) : ptr_ff - IW'(1);
               if (ptr_ff == end_ff) begin
                  more_in = 1'b0;
               end
            end
            // consume the entry read last cycle
            if (rd_vld_ff) begin
               unique case (func_ff) inside
                  FN_INS_END, FN_INS_FRONT, FN_INS_AT: begin
                     mem_ctl.wr_en = 1'b1;
                     wr_addr       = addr_q_ff + IW'(1);
                     wr_data       = rd_data;
                  end
                  FN_DEL_FRONT, FN_DEL_AT: begin
                     mem_ctl.wr_en = 1'b1;
                     wr_addr       = addr_q_ff - IW'(1);
                     wr_data       = rd_data;
                  end
                  FN_SUM: begin
                     acc_in = acc_ff + rd_data;
                  end
                  FN_SEARCH: begin
                     if (rd_data == value_ff) begin
                        res_found_in = addr_q_ff;
                        state_in     = SQ_FINISH;
                     end
                  end
                  FN_READ: begin
                     acc_in = rd_data;
                  end
                  default: begin
                  end
               endcase
            end
            // walk drained: finish the command
            if (!more_ff && !rd_vld_ff) begin
               state_in = SQ_FINISH;
               unique case (func_ff) inside
                  FN_INS_END, FN_INS_FRONT, FN_INS_AT: begin
                     mem_ctl.wr_en = 1'b1;
                     wr_addr       = end_ff;
                     wr_data       = value_ff;
                     count_in      = count_ff + CW'(1);
                  end
                  FN_DEL_FRONT, FN_DEL_AT: begin
                     count_in = count_ff - CW'(1);
                  end
                  FN_SEARCH: begin
                     res_status_in = ST_NOTFOUND;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // reverse: read low, read high, write low, write high
         SQ_REV_RLO: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = ptr_ff;
            state_in      = SQ_REV_RHI;
         end
         SQ_REV_RHI: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = end_ff;
            tmp_in        = rd_data;
            state_in      = SQ_REV_WLO;
         end
         SQ_REV_WLO: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = ptr_ff;
            wr_data       = rd_data;
            state_in      = SQ_REV_WHI;
         end
         SQ_REV_WHI: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = end_ff;
            wr_data       = tmp_ff;
            ptr_in        = ptr_ff + IW'(1);
            end_in        = end_ff - IW'(1);
            if (({1'b0, ptr_ff} + (IW+1)'(2)) < {1'b0, end_ff}) begin
               state_in = SQ_REV_RLO;
            end else begin
               state_in = SQ_FINISH;
            end
         end

         SQ_FINISH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = acc_ff;
               rsp_found_in  = POS_W'(res_found_ff);
               rsp_fill_in   = POS_W'(count_ff);
               state_in      = SQ_IDLE;
            end
         end

         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SQ_IDLE;
         count_ff      <= '0;
         more_ff       <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         more_ff       <= more_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      up_ff         <= up_in;
      addr_q_ff     <= addr_q_in;
      tmp_ff        <= tmp_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_fill_ff, rsp_found_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

FILE: rtl/core/pale_checker.sv
// ----------------------------------------------------------------------------
// pale_checker
// port-level checks of the positional array list engine
// ----------------------------------------------------------------------------
`include "positional_array_list_engine_assert.svh"

module pale_checker #(
   parameter int CAPACITY = pale_pkg::CAPACITY_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pale_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [pale_pkg::STATUS_W-1:0]    rsp_tuser
);
   import pale_pkg::*;

   // fill count never passes the capacity
   `PALE_ASSERT_NOW(a_fill_bound, rsp_tvalid, rsp_tdata[47:40] <= 8'(CAPACITY))

   // errors and a failed search carry zero data and zero index
   `PALE_ASSERT_NOW(a_err_zero, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata[39:0] == '0)

   // one command at a time: busy right after an accepted item
   `PALE_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

   // a stalled result holds
   `PALE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind positional_array_list_engine pale_checker #(.CAPACITY(CAPACITY)) u_pale_checker (.*);

FILE: dv/tb_positional_array_list_engine.sv
// ----------------------------------------------------------------------------
// tb_positional_array_list_engine
// self-checking bench for the positional array list engine: a short table of
// directed commands, then random command runs (fill, drain, mixed and noise)
// under several sender and receiver idling phases; every result is compared
// field by field with the row's own result where a table row gives one, else
// with a list predictor kept in step with each accepted item
module tb_positional_array_list_engine;
   import pale_pkg::*;

   localparam int CAP         = CAPACITY_DEF;
   localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either side
   localparam int DRAIN_WAIT  = 40;     // tail after the last result
   localparam int MAX_REPORTS = 40;

   // selector codes the block must ignore
   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd13;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;

   // one result item, split into its fields
   typedef struct packed {
      pale_status_type    status;
      logic [DATA_W-1:0]  data;
      logic [POS_W-1:0]   found_index;
      logic [POS_W-1:0]   fill_count;
   } list_result_type;

   // one row of the directed table; want is used only where typed is set
   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] value;
      logic [POS_W-1:0]  position;
      bit                typed;
      list_result_type   want;
   } list_cmd_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // value[31:0], position[39:32]
   logic [FUNC_W-1:0]     req_tuser = '0;   // func[3:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // data[31:0], found_index[39:32], fill_count[47:40]
   logic [STATUS_W-1:0]   rsp_tuser;        // status[2:0]

   // mirror of the list held by the block
   logic [DATA_W-1:0] mirror_entries [CAP];
   int                mirror_count;

   list_result_type   pending_results [$];
   list_cmd_row_type  directed_rows [$];

   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int error_count     = 0;
   int peak_fill       = 0;
   int quiet_cycles    = 0;
   int status_tally [5];

   positional_array_list_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 8 unit clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // -------------------------------------------------------------------------
   // list predictor: applies one command to the mirror and returns its result
   // -------------------------------------------------------------------------
   function automatic list_result_type predict_list_result(input logic [FUNC_W-1:0] func,
                                                           input logic [DATA_W-1:0] value,
                                                           input logic [POS_W-1:0]  position);
      list_result_type   r;
      int                at;
      bit                hit;
      logic [DATA_W-1:0] swap;
      r        = '0;
      r.status = ST_OK;
      hit      = 1'b0;
      case (func) inside
         FN_INS_END, FN_INS_FRONT, FN_INS_AT: begin
            // full is checked before the position
            if (mirror_count >= CAP) begin
               r.status = ST_FULL;
            end else begin
               if (func == FN_INS_END) at = mirror_count;
               else if (func == FN_INS_FRONT) at = 0;
               else at = position;
               if (at > mirror_count) begin
                  r.status = ST_BADPOS;
               end else begin
                  for (int i = mirror_count; i > at; i--) mirror_entries[i] = mirror_entries[i-1];
                  mirror_entries[at] = value;
                  mirror_count++;
               end
            end
         end
         FN_MOD_END: begin
            if (mirror_count == 0) r.status = ST_EMPTY;
            else mirror_entries[mirror_count-1] = value;
         end
         FN_MOD_FRONT: begin
            if (mirror_count == 0) r.status = ST_EMPTY;
            else mirror_entries[0] = value;
         end
         FN_MOD_AT: begin
            if (position >= mirror_count) r.status = ST_BADPOS;
            else mirror_entries[position] = value;
         end
         FN_DEL_END: begin
            if (mirror_count == 0) r.status = ST_EMPTY;
            else mirror_count--;
         end
         FN_DEL_FRONT, FN_DEL_AT: begin
            // empty wins over a bad position
            if (mirror_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               at = (func == FN_DEL_FRONT) ? 0 : position;
               if (at >= mirror_count) begin
                  r.status = ST_BADPOS;
               end else begin
                  for (int i = at; i + 1 < mirror_count; i++) mirror_entries[i] = mirror_entries[i+1];
                  mirror_count--;
               end
            end
         end
         FN_REVERSE: begin
            for (int i = 0; i < mirror_count / 2; i++) begin
               swap = mirror_entries[i];
               mirror_entries[i] = mirror_entries[mirror_count-1-i];
               mirror_entries[mirror_count-1-i] = swap;
            end
         end
         FN_SUM: begin
            for (int i = 0; i < mirror_count; i++) r.data = r.data + mirror_entries[i];
         end
         FN_SEARCH: begin
            // first match only
            r.status = ST_NOTFOUND;
            for (int i = 0; i < mirror_count; i++) begin
               if (!hit && mirror_entries[i] == value) begin
                  hit           = 1'b1;
                  r.status      = ST_OK;
                  r.found_index = POS_W'(i);
               end
            end
         end
         FN_READ: begin
            if (position >= mirror_count) r.status = ST_BADPOS;
            else r.data = mirror_entries[position];
         end
         default: ;   // spare selectors change nothing
      endcase
      r.fill_count = POS_W'(mirror_count);
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // command driver: one item per call, entered and left on a falling edge
   // -------------------------------------------------------------------------
   task automatic issue_cmd(input logic [FUNC_W-1:0] func,
                            input logic [DATA_W-1:0] value,
                            input logic [POS_W-1:0]  position,
                            input bit                typed = 1'b0,
                            input list_result_type   want = '0);
      list_result_type model;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {position, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted on this edge: advance the mirror and queue the result
      model = predict_list_result(func, value, position);
      pending_results.push_back(typed ? want : model);
      items_sent++;
      if (mirror_count > peak_fill) peak_fill = mirror_count;
      @(negedge clock);
   endtask

   // sender holds off until every queued result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // values lean on the extremes and on small numbers that repeat
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return DATA_W'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   // positions mostly inside the list, sometimes on or past its end
   function automatic logic [POS_W-1:0] pick_position();
      case ($urandom_range(9))
         0: return POS_W'($urandom_range(255));
         1: return POS_W'(mirror_count);
         2: return POS_W'(mirror_count + 1);
         default: return POS_W'($urandom_range(mirror_count));
      endcase
   endfunction

   // insert of a random kind, always at a legal place
   task automatic issue_insert();
      case ($urandom_range(2))
         0: issue_cmd(FN_INS_END, pick_value(), POS_W'($urandom_range(255)));
         1: issue_cmd(FN_INS_FRONT, pick_value(), POS_W'($urandom_range(255)));
         default: issue_cmd(FN_INS_AT, pick_value(), POS_W'($urandom_range(mirror_count)));
      endcase
   endtask

   // delete of a random kind, always of an existing entry when there is one
   task automatic issue_delete();
      case ($urandom_range(2))
         0: issue_cmd(FN_DEL_END, $urandom, POS_W'($urandom_range(255)));
         1: issue_cmd(FN_DEL_FRONT, $urandom, POS_W'($urandom_range(255)));
         default: issue_cmd(FN_DEL_AT, $urandom,
                            POS_W'(mirror_count == 0 ? 0 : $urandom_range(mirror_count - 1)));
      endcase
   endtask

   // any command, shaped by what the list holds now
   task automatic issue_mixed();
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] value;
      if ($urandom_range(39) == 0) func = FUNC_W'(FN_SPARE_LO + $urandom_range(2));
      else func = FUNC_W'($urandom_range(12));
      value = pick_value();
      // searches mostly look for something that is there
      if (func == FN_SEARCH && mirror_count != 0 && $urandom_range(3) != 0)
         value = mirror_entries[$urandom_range(mirror_count - 1)];
      issue_cmd(func, value, pick_position());
   endtask

   // -------------------------------------------------------------------------
   // one random phase: runs of well-formed commands, some noise, one hold-off
   // -------------------------------------------------------------------------
   task automatic run_phase(input int n_items, input int send_pct, input int stall_pct);
      int  target;
      int  extra;
      bit  held;
      target = items_sent + n_items;
      held   = 1'b0;
      while (items_sent < target) begin
         // now and then a stretch with no idling at all
         if ($urandom_range(5) == 0) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            send_idle_pct = send_pct;
            rsp_stall_pct = stall_pct;
         end
         if (!held && items_sent >= target - n_items / 2) begin
            wait_drained();
            held = 1'b1;
         end
         case ($urandom_range(9))
            0, 1: begin
               // fill to capacity, then push against the full list
               while (mirror_count < CAP) issue_insert();
               extra = 1 + $urandom_range(1);
               repeat (extra) begin
                  if ($urandom_range(1) == 0) issue_insert();
                  else issue_cmd(FN_INS_AT, pick_value(), POS_W'($urandom_range(255)));
               end
            end
            2, 3: begin
               // drain to empty with a few looks along the way
               while (mirror_count > 0) begin
                  if ($urandom_range(3) == 0) issue_mixed();
                  else issue_delete();
               end
               issue_mixed();
            end
            9: begin
               // noise: any selector, any value, any position
               repeat (4) issue_cmd(FUNC_W'($urandom_range(15)), $urandom,
                                    POS_W'($urandom_range(255)));
            end
            default: repeat (8) issue_mixed();
         endcase
      end
   endtask

   // -------------------------------------------------------------------------
   // result checker: oldest expectation against each accepted result item
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("MISMATCH at %0t, result %0d: %s", $time, results_checked, what);
   endtask

   always @(posedge clock) begin : result_check
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser < 5) status_tally[rsp_tuser]++;
         if (pending_results.size() == 0) begin
            report_mismatch("result item with nothing pending");
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_tuser, want.status));
            if (rsp_tdata[31:0] !== want.data)
               report_mismatch($sformatf("data %h, want %h", rsp_tdata[31:0], want.data));
            if (rsp_tdata[39:32] !== want.found_index)
               report_mismatch($sformatf("found_index %0d, want %0d",
                                         rsp_tdata[39:32], want.found_index));
            if (rsp_tdata[47:40] !== want.fill_count)
               report_mismatch($sformatf("fill_count %0d, want %0d",
                                         rsp_tdata[47:40], want.fill_count));
         end
         results_checked++;
      end
   end

   // watchdog: ends a run in which no item moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      mirror_count = 0;
      foreach (mirror_entries[i]) mirror_entries[i] = '0;
      foreach (status_tally[i]) status_tally[i] = 0;

      // directed table; typed results only where they are plain to see
      // empty list: every error path that can fire on it, plus sum and reverse
      directed_rows.push_back('{FN_DEL_END,   32'd0, 8'd0, 1'b1, '{ST_EMPTY, 32'd0, 8'd0, 8'd0}});
      directed_rows.push_back('{FN_DEL_FRONT, 32'd0, 8'd0, 1'b1, '{ST_EMPTY, 32'd0, 8'd0, 8'd0}});
      directed_rows.push_back('{FN_DEL_AT,    32'd0, 8'd0, 1'b1, '{ST_EMPTY, 32'd0, 8'd0, 8'd0}});
      directed_rows.push_back('{FN_MOD_END,   32'd5, 8'd0, 1'b1, '{ST_EMPTY, 32'd0, 8'd0, 8'd0}});
      directed_rows.push_back('{FN_MOD_FRONT, 32'd5, 8'd0, 1'b1, '{ST_EMPTY, 32'd0, 8'd0, 8'd0}});
      directed_rows.push_back('{FN_MOD_AT,    32'd5, 8'd0, 1'b1, '{ST_BADPOS, 32'd0, 8'd0, 8'd0}});
      directed_rows.push_back('{FN_READ,      32'd0, 8'd0, 1'b1, '{ST_BADPOS, 32'd0, 8'd0, 8'd0}});
      directed_rows.push_back('{FN_SEARCH,    32'd0, 8'd0, 1'b1,
                                '{ST_NOTFOUND, 32'd0, 8'd0, 8'd0}});
      directed_rows.push_back('{FN_SUM,       32'd0, 8'd0, 1'b1, '{ST_OK, 32'd0, 8'd0, 8'd0}});
      directed_rows.push_back('{FN_REVERSE,   32'd0, 8'd0, 1'b1, '{ST_OK, 32'd0, 8'd0, 8'd0}});
      directed_rows.push_back('{FN_INS_AT,    32'd9, 8'd1, 1'b1, '{ST_BADPOS, 32'd0, 8'd0, 8'd0}});
      // three entries at the value extremes; the sum wraps
      directed_rows.push_back('{FN_INS_END,   32'h7fff_ffff, 8'd0, 1'b1,
                                '{ST_OK, 32'd0, 8'd0, 8'd1}});
      directed_rows.push_back('{FN_INS_FRONT, 32'h8000_0000, 8'd0, 1'b1,
                                '{ST_OK, 32'd0, 8'd0, 8'd2}});
      directed_rows.push_back('{FN_INS_AT,    32'hffff_ffff, 8'd2, 1'b1,
                                '{ST_OK, 32'd0, 8'd0, 8'd3}});
      directed_rows.push_back('{FN_SUM,       32'd0, 8'd0, 1'b1,
                                '{ST_OK, 32'hffff_fffe, 8'd0, 8'd3}});
      directed_rows.push_back('{FN_SEARCH,    32'hffff_ffff, 8'd0, 1'b1,
                                '{ST_OK, 32'd0, 8'd2, 8'd3}});
      directed_rows.push_back('{FN_REVERSE,   32'd0, 8'd0, 1'b0, '0});
      directed_rows.push_back('{FN_READ,      32'd0, 8'd0, 1'b0, '0});
      // positions past the end, the top position among them, then valid modifies and deletes
      directed_rows.push_back('{FN_MOD_AT,    32'd1, 8'd255, 1'b1,
                                '{ST_BADPOS, 32'd0, 8'd0, 8'd3}});
      directed_rows.push_back('{FN_DEL_AT,    32'd0, 8'd3, 1'b1,
                                '{ST_BADPOS, 32'd0, 8'd0, 8'd3}});
      directed_rows.push_back('{FN_MOD_END,   32'd1, 8'd0, 1'b0, '0});
      directed_rows.push_back('{FN_MOD_AT,    32'h5a5a_5a5a, 8'd1, 1'b0, '0});
      directed_rows.push_back('{FN_DEL_AT,    32'd0, 8'd1, 1'b0, '0});
      directed_rows.push_back('{FN_DEL_FRONT, 32'd0, 8'd0, 1'b0, '0});
      // spare selector leaves the list alone
      directed_rows.push_back('{FN_SPARE_HI,  32'hdead_beef, 8'd7, 1'b1,
                                '{ST_OK, 32'd0, 8'd0, 8'd1}});

      // reset held, then released on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         issue_cmd(directed_rows[i].func, directed_rows[i].value, directed_rows[i].position,
                   directed_rows[i].typed, directed_rows[i].want);

      // random phases: no idling, sender idle, receiver stalls, both
      run_phase(350, 0, 0);
      run_phase(350, 49, 0);
      run_phase(350, 0, 49);
      run_phase(350, 20, 20);

      // let the last results come back, then a short tail for strays
      req_tvalid    <= 1'b0;
      rsp_stall_pct = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("summary: %0d commands sent, %0d results checked, list filled up to %0d of %0d",
               items_sent, results_checked, peak_fill, CAP);
      $display("summary: status ok %0d, full %0d, bad position %0d, empty %0d, not found %0d",
               status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_BADPOS],
               status_tally[ST_EMPTY], status_tally[ST_NOTFOUND]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
